### src/assert_macros.svh
// assertion helpers used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define M4I_ASSERT_IMP(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("m4i assertion failed");

// next-cycle implication
`define M4I_ASSERT_NXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("m4i assertion failed");

`endif

### src/m4i_pkg.sv
package m4i_pkg;

  localparam int FRAC_BITS = 16;
  localparam int EW        = 32;                 // entry width
  localparam int THR_W     = 63;                 // threshold register width
  localparam int PW        = 66;                 // product width
  localparam int CFW       = 97;                 // cofactor width
  localparam int DETW      = 130;                // determinant width
  localparam int ADW       = 129;                // determinant magnitude width
  localparam int QB        = 34;                 // quotient bits
  localparam int DW        = ADW + QB;           // divider word width
  localparam int IT_W      = $clog2(QB);
  localparam int THR_SH    = 4 * FRAC_BITS - 32;
  localparam int NUM_SH    = 2 * FRAC_BITS;

  localparam logic [EW-1:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [EW-1:0] SAT_NEG = 32'h8000_0000;

  typedef enum logic [3:0] {
    S_LOAD,
    S_CF,
    S_CFW,
    S_DET,
    S_DETW,
    S_ABS,
    S_CHK,
    S_DLD,
    S_DOV,
    S_DIT,
    S_DRND,
    S_OUT
  } state_t;

  typedef enum logic [2:0] {
    MOP_NONE,
    MOP_LAT,
    MOP_E12,
    MOP_LO,
    MOP_HI,
    MOP_COF
  } mop_t;

  typedef struct packed {
    logic       st_we;
    logic [3:0] st_addr;
    logic [3:0] rd_addr;
    mop_t       mop;
    logic       neg;
    logic [1:0] chunk;
    logic       acc_clr;
    logic       cof_we;
    logic [3:0] cof_addr;
    logic       det_ld;
    logic       abs_ld;
    logic       d_ld;
    logic       d_ov;
    logic       d_it;
    logic       d_rnd;
    logic       out_sing;
    logic [3:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic singular;
  } sts_t;

endpackage

### src/m4i_if.sv
interface m4i_in_if;
  logic                           valid;
  logic                           ready;
  logic signed [m4i_pkg::EW-1:0]  entry_value;
  logic                           first_entry;
  modport source(output valid, entry_value, first_entry, input ready);
  modport sink(input valid, entry_value, first_entry, output ready);
endinterface

interface m4i_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [m4i_pkg::EW-1:0]  inverse_value;
  logic [3:0]                     entry_index;
  logic                           singular;
  logic                           clipped;
  logic                           last_result;
  modport source(output valid, inverse_value, entry_index, singular, clipped, last_result,
                 input ready);
  modport sink(input valid, inverse_value, entry_index, singular, clipped, last_result,
               output ready);
endinterface

interface m4i_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [m4i_pkg::THR_W-1:0]       data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### src/mat4_inverse_cofactor.sv
// 4x4 matrix inverse by adjugate, signed Q16.16.
// in_ch: one entry word per transfer, row-major; first_entry restarts the
//   load at position 0. Accepted one per cycle while loading.
// out_ch: 16 inverse words (entry_index 0..15, last_result on 15), or a
//   single word flagged singular when |det| is zero or under the threshold.
// cfg_ch: singular_threshold (Q31.32 magnitude), always ready; write only
//   while idle.
// After the 16th entry the cofactors are formed on one shared multiplier
//   (6 terms each, built as latch, product, low and high part), then the
//   determinant, then the threshold check. Each inverse word then passes
//   the one-bit-per-cycle divider plus the output handshake.
// The input is not taken while a matrix is being computed or emitted; a
//   stalled receiver holds the result word and halts the sequencer.
// Reset (rst_n low, synchronous) returns to loading at position 0 and sets
//   the threshold to 1.
module mat4_inverse_cofactor (
  input  logic         clk,
  input  logic         rst_n,
  m4i_in_if.sink       in_ch,
  m4i_out_if.source    out_ch,
  m4i_cfg_if.sink      cfg_ch
);

  m4i_pkg::cmd_t cmd;
  m4i_pkg::sts_t sts;

  assign cfg_ch.ready = 1'b1;

  m4i_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_first  (in_ch.first_entry),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  m4i_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_ch.entry_value),
    .cfg_we       (cfg_ch.valid),
    .cfg_data     (cfg_ch.data),
    .out_value    (out_ch.inverse_value),
    .out_index    (out_ch.entry_index),
    .out_singular (out_ch.singular),
    .out_clipped  (out_ch.clipped),
    .out_last     (out_ch.last_result)
  );

endmodule

### src/m4i_ctrl.sv
module m4i_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_first,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  m4i_pkg::sts_t sts,
  output m4i_pkg::cmd_t cmd
);

  m4i_pkg::state_t state_r, state_nxt;
  logic [3:0]                 ld_cnt_r, ld_cnt_nxt;
  logic [3:0]                 cf_k_r, cf_k_nxt;
  logic [2:0]                 t_r, t_nxt;
  logic [1:0]                 p_r, p_nxt;
  logic [1:0]                 ch_r, ch_nxt;
  logic [1:0]                 dk_r, dk_nxt;
  logic [m4i_pkg::IT_W-1:0]   it_r, it_nxt;
  logic [3:0]                 ok_r, ok_nxt;
  logic [3:0]                 ld_idx;
  logic                       in_fire;

  function automatic logic [1:0] skip_idx(input logic [1:0] i, input logic [1:0] x);
    return (i < x) ? i : i + 2'd1;
  endfunction

  // permutation of the 3x3 minor columns for term t
  function automatic logic [1:0] perm_sel(input logic [2:0] t, input logic [1:0] pos);
    logic [5:0] pm;
    case (t)
      3'd0:    pm = {2'd2, 2'd1, 2'd0};
      3'd1:    pm = {2'd1, 2'd2, 2'd0};
      3'd2:    pm = {2'd2, 2'd0, 2'd1};
      3'd3:    pm = {2'd0, 2'd2, 2'd1};
      3'd4:    pm = {2'd1, 2'd0, 2'd2};
      default: pm = {2'd0, 2'd1, 2'd2};
    endcase
    case (pos)
      2'd0:    return pm[1:0];
      2'd1:    return pm[3:2];
      default: return pm[5:4];
    endcase
  endfunction

  function automatic logic [3:0] cf_addr(input logic [3:0] k, input logic [2:0] t,
                                         input logic [1:0] p);
    logic [1:0] pos;
    pos = (p == 2'd3) ? 2'd2 : p;
    return {skip_idx(pos, k[3:2]), skip_idx(perm_sel(t, pos), k[1:0])};
  endfunction

  function automatic logic cf_neg(input logic [3:0] k, input logic [2:0] t);
    logic ps;
    ps = (t == 3'd1) || (t == 3'd2) || (t == 3'd5);
    return ps ^ k[2] ^ k[0];
  endfunction

  assign in_ready  = (state_r == m4i_pkg::S_LOAD);
  assign out_valid = (state_r == m4i_pkg::S_OUT);
  assign in_fire   = in_valid && in_ready;
  assign ld_idx    = in_first ? 4'd0 : ld_cnt_r;

  always_comb begin
    state_nxt  = state_r;
    ld_cnt_nxt = ld_cnt_r;
    cf_k_nxt   = cf_k_r;
    t_nxt      = t_r;
    p_nxt      = p_r;
    ch_nxt     = ch_r;
    dk_nxt     = dk_r;
    it_nxt     = it_r;
    ok_nxt     = ok_r;
    unique case (state_r)
      m4i_pkg::S_LOAD: begin
        if (in_fire) begin
          ld_cnt_nxt = ld_idx + 4'd1;
          if (ld_idx == 4'd15) begin
            state_nxt = m4i_pkg::S_CF;
            cf_k_nxt  = 4'd0;
            t_nxt     = 3'd0;
            p_nxt     = 2'd0;
          end
        end
      end
      m4i_pkg::S_CF: begin
        p_nxt = p_r + 2'd1;
        if (p_r == 2'd3) begin
          t_nxt = t_r + 3'd1;
          if (t_r == 3'd5) begin
            t_nxt     = 3'd0;
            state_nxt = m4i_pkg::S_CFW;
          end
        end
      end
      m4i_pkg::S_CFW: begin
        cf_k_nxt = cf_k_r + 4'd1;
        if (cf_k_r == 4'd15) begin
          state_nxt = m4i_pkg::S_DET;
          dk_nxt    = 2'd0;
          ch_nxt    = 2'd0;
        end else begin
          state_nxt = m4i_pkg::S_CF;
        end
      end
      m4i_pkg::S_DET: begin
        ch_nxt = ch_r + 2'd1;
        if (ch_r == 2'd2) begin
          ch_nxt = 2'd0;
          dk_nxt = dk_r + 2'd1;
          if (dk_r == 2'd3) state_nxt = m4i_pkg::S_DETW;
        end
      end
      m4i_pkg::S_DETW: state_nxt = m4i_pkg::S_ABS;
      m4i_pkg::S_ABS:  state_nxt = m4i_pkg::S_CHK;
      m4i_pkg::S_CHK: begin
        ok_nxt    = 4'd0;
        state_nxt = sts.singular ? m4i_pkg::S_OUT : m4i_pkg::S_DLD;
      end
      m4i_pkg::S_DLD: state_nxt = m4i_pkg::S_DOV;
      m4i_pkg::S_DOV: begin
        it_nxt    = '0;
        state_nxt = m4i_pkg::S_DIT;
      end
      m4i_pkg::S_DIT: begin
        it_nxt = it_r + 1'b1;
        if (it_r == m4i_pkg::IT_W'(m4i_pkg::QB - 1)) state_nxt = m4i_pkg::S_DRND;
      end
      m4i_pkg::S_DRND: state_nxt = m4i_pkg::S_OUT;
      m4i_pkg::S_OUT: begin
        if (out_ready) begin
          if (sts.singular || ok_r == 4'd15) begin
            state_nxt = m4i_pkg::S_LOAD;
          end else begin
            ok_nxt    = ok_r + 4'd1;
            state_nxt = m4i_pkg::S_DLD;
          end
        end
      end
      default: state_nxt = m4i_pkg::S_LOAD;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.mop      = m4i_pkg::MOP_NONE;
    cmd.st_addr  = ld_idx;
    cmd.out_idx  = ok_r;
    unique case (state_r)
      m4i_pkg::S_LOAD: begin
        cmd.st_we   = in_fire;
        cmd.acc_clr = in_fire && (ld_idx == 4'd15);
      end
      m4i_pkg::S_CF: begin
        cmd.rd_addr = cf_addr(cf_k_r, t_r, p_r);
        cmd.neg     = cf_neg(cf_k_r, t_r);
        case (p_r)
          2'd0:    cmd.mop = m4i_pkg::MOP_LAT;
          2'd1:    cmd.mop = m4i_pkg::MOP_E12;
          2'd2:    cmd.mop = m4i_pkg::MOP_LO;
          default: cmd.mop = m4i_pkg::MOP_HI;
        endcase
      end
      m4i_pkg::S_CFW: begin
        cmd.cof_we   = 1'b1;
        cmd.cof_addr = cf_k_r;
        cmd.acc_clr  = 1'b1;
      end
      m4i_pkg::S_DET: begin
        cmd.mop      = m4i_pkg::MOP_COF;
        cmd.rd_addr  = {2'b00, dk_r};
        cmd.cof_addr = {2'b00, dk_r};
        cmd.chunk    = ch_r;
      end
      m4i_pkg::S_DETW: begin
        cmd.det_ld  = 1'b1;
        cmd.acc_clr = 1'b1;
      end
      m4i_pkg::S_ABS: cmd.abs_ld = 1'b1;
      m4i_pkg::S_CHK: cmd.out_sing = sts.singular;
      m4i_pkg::S_DLD: begin
        cmd.d_ld     = 1'b1;
        cmd.cof_addr = {ok_r[1:0], ok_r[3:2]};
      end
      m4i_pkg::S_DOV:  cmd.d_ov  = 1'b1;
      m4i_pkg::S_DIT:  cmd.d_it  = 1'b1;
      m4i_pkg::S_DRND: cmd.d_rnd = 1'b1;
      m4i_pkg::S_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= m4i_pkg::S_LOAD;
      ld_cnt_r <= 4'd0;
      cf_k_r   <= 4'd0;
      t_r      <= 3'd0;
      p_r      <= 2'd0;
      ch_r     <= 2'd0;
      dk_r     <= 2'd0;
      it_r     <= '0;
      ok_r     <= 4'd0;
    end else begin
      state_r  <= state_nxt;
      ld_cnt_r <= ld_cnt_nxt;
      cf_k_r   <= cf_k_nxt;
      t_r      <= t_nxt;
      p_r      <= p_nxt;
      ch_r     <= ch_nxt;
      dk_r     <= dk_nxt;
      it_r     <= it_nxt;
      ok_r     <= ok_nxt;
    end
  end

endmodule

### src/m4i_dp.sv
module m4i_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  m4i_pkg::cmd_t                    cmd,
  output m4i_pkg::sts_t                    sts,
  input  logic signed [m4i_pkg::EW-1:0]    in_value,
  input  logic                             cfg_we,
  input  logic [m4i_pkg::THR_W-1:0]        cfg_data,
  output logic signed [m4i_pkg::EW-1:0]    out_value,
  output logic [3:0]                       out_index,
  output logic                             out_singular,
  output logic                             out_clipped,
  output logic                             out_last
);

  localparam int EW   = m4i_pkg::EW;
  localparam int PW   = m4i_pkg::PW;
  localparam int CFW  = m4i_pkg::CFW;
  localparam int DETW = m4i_pkg::DETW;
  localparam int ADW  = m4i_pkg::ADW;
  localparam int QB   = m4i_pkg::QB;
  localparam int DW   = m4i_pkg::DW;

  logic [EW-1:0]             store_r [16];
  logic [CFW-1:0]            cof_r [16];
  logic [m4i_pkg::THR_W-1:0] thr_r;

  logic signed [EW-1:0]      ent;
  logic [CFW-1:0]            cof_rd;
  logic signed [EW-1:0]      lat_r;
  logic signed [EW-1:0]      hold_r;
  logic signed [EW+1:0]      mul_a;
  logic signed [PW-1:0]      mul_p;
  logic signed [PW-1:0]      prod_r;
  logic                      pend_r;
  logic [1:0]                pend_sh_r;
  logic                      pend_neg_r;
  logic signed [DETW-1:0]    pext, pshift, term, acc_sum;
  logic signed [DETW-1:0]    acc_r;
  logic signed [DETW-1:0]    det_r;
  logic [DETW-1:0]           dmag;
  logic [ADW-1:0]            adet_r;
  logic                      dneg_r;
  logic [ADW-1:0]            thr_sh;

  logic [CFW-1:0]            cabs;
  logic [DW-1:0]             rem_r, dsh_r, diff;
  logic                      ge;
  logic [QB-1:0]             q_r;
  logic                      qneg_r;
  logic                      over_r;
  logic                      rbit;
  logic [QB:0]               qr;
  logic                      clip;
  logic [EW-1:0]             val;

  assign ent    = store_r[cmd.rd_addr];
  assign cof_rd = cof_r[cmd.cof_addr];

  always_comb begin
    unique case (cmd.mop)
      m4i_pkg::MOP_E12: mul_a = {{2{lat_r[EW-1]}}, lat_r};
      m4i_pkg::MOP_LO:  mul_a = {2'b00, prod_r[EW-1:0]};
      m4i_pkg::MOP_HI:  mul_a = {{2{hold_r[EW-1]}}, hold_r};
      m4i_pkg::MOP_COF: begin
        case (cmd.chunk)
          2'd0:    mul_a = {2'b00, cof_rd[EW-1:0]};
          2'd1:    mul_a = {2'b00, cof_rd[2*EW-1:EW]};
          default: mul_a = {cof_rd[CFW-1], cof_rd[CFW-1:2*EW]};
        endcase
      end
      default: mul_a = '0;
    endcase
  end

  assign mul_p = mul_a * ent;

  always_comb begin
    pext = {{(DETW-PW){prod_r[PW-1]}}, prod_r};
    case (pend_sh_r)
      2'd0:    pshift = pext;
      2'd1:    pshift = pext <<< EW;
      default: pshift = pext <<< (2 * EW);
    endcase
    term    = pend_neg_r ? -pshift : pshift;
    acc_sum = acc_r + (pend_r ? term : '0);
  end

  always_ff @(posedge clk) begin
    if (cmd.st_we) store_r[cmd.st_addr] <= in_value;
    if (cmd.mop == m4i_pkg::MOP_LAT) lat_r <= ent;
    if (cmd.mop == m4i_pkg::MOP_LO) hold_r <= prod_r[2*EW-1:EW];
    if (cmd.mop == m4i_pkg::MOP_E12 || cmd.mop == m4i_pkg::MOP_LO ||
        cmd.mop == m4i_pkg::MOP_HI || cmd.mop == m4i_pkg::MOP_COF) begin
      prod_r <= mul_p;
    end
    pend_sh_r  <= (cmd.mop == m4i_pkg::MOP_HI)  ? 2'd1 :
                  (cmd.mop == m4i_pkg::MOP_COF) ? cmd.chunk : 2'd0;
    pend_neg_r <= cmd.neg;
    acc_r      <= cmd.acc_clr ? '0 : acc_sum;
    if (cmd.cof_we) cof_r[cmd.cof_addr] <= acc_sum[CFW-1:0];
    if (cmd.det_ld) det_r <= acc_sum;
    if (cmd.abs_ld) begin
      dneg_r <= det_r[DETW-1];
      adet_r <= dmag[ADW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
      thr_r  <= m4i_pkg::THR_W'(1);
    end else begin
      pend_r <= (cmd.mop == m4i_pkg::MOP_LO) || (cmd.mop == m4i_pkg::MOP_HI) ||
                (cmd.mop == m4i_pkg::MOP_COF);
      if (cfg_we) thr_r <= cfg_data;
    end
  end

  assign dmag         = det_r[DETW-1] ? -det_r : det_r;
  assign thr_sh       = {{(ADW-m4i_pkg::THR_W){1'b0}}, thr_r} << m4i_pkg::THR_SH;
  assign sts.singular = (adet_r == '0) || (adet_r < thr_sh);

  // restoring division, one quotient bit a cycle
  assign cabs = cof_rd[CFW-1] ? -cof_rd : cof_rd;
  assign ge   = rem_r >= dsh_r;
  assign diff = rem_r - dsh_r;
  assign rbit = {rem_r, 1'b0} >= {{(DW+1-ADW){1'b0}}, adet_r};
  assign qr   = {1'b0, q_r} + (QB+1)'(rbit);

  always_comb begin
    if (qneg_r) begin
      clip = over_r || (qr > (QB+1)'(m4i_pkg::SAT_NEG));
      val  = clip ? m4i_pkg::SAT_NEG : -qr[EW-1:0];
    end else begin
      clip = over_r || (qr > (QB+1)'(m4i_pkg::SAT_POS));
      val  = clip ? m4i_pkg::SAT_POS : qr[EW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.d_ld) begin
      rem_r  <= {{(DW-CFW){1'b0}}, cabs} << m4i_pkg::NUM_SH;
      dsh_r  <= {{(DW-ADW){1'b0}}, adet_r} << QB;
      qneg_r <= cof_rd[CFW-1] ^ dneg_r;
    end
    if (cmd.d_ov) begin
      over_r <= ge;
      dsh_r  <= {1'b0, dsh_r[DW-1:1]};
      q_r    <= '0;
    end
    if (cmd.d_it) begin
      if (ge) rem_r <= diff;
      q_r   <= {q_r[QB-2:0], ge};
      dsh_r <= {1'b0, dsh_r[DW-1:1]};
    end
    if (cmd.out_sing) begin
      out_value    <= '0;
      out_index    <= 4'd0;
      out_singular <= 1'b1;
      out_clipped  <= 1'b0;
      out_last     <= 1'b1;
    end else if (cmd.d_rnd) begin
      out_value    <= val;
      out_index    <= cmd.out_idx;
      out_singular <= 1'b0;
      out_clipped  <= clip;
      out_last     <= (cmd.out_idx == 4'd15);
    end
  end

endmodule

### src/m4i_checker.sv
`include "assert_macros.svh"

module m4i_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [m4i_pkg::EW-1:0]        out_value,
  input logic [3:0]                    out_index,
  input logic                          out_singular,
  input logic                          out_clipped,
  input logic                          out_last
);

  `M4I_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `M4I_ASSERT_IMP(a_no_load_busy, clk, rst_n, out_valid, !in_ready)
  `M4I_ASSERT_IMP(a_sing_word, clk, rst_n, out_valid && out_singular, out_last && out_index == 4'd0 && out_value == '0 && !out_clipped)
  `M4I_ASSERT_IMP(a_last_idx, clk, rst_n, out_valid && !out_singular, out_last == (out_index == 4'd15))
  `M4I_ASSERT_NXT(a_more_follow, clk, rst_n, out_valid && out_ready && !out_last, !in_ready)

endmodule

bind mat4_inverse_cofactor m4i_checker u_m4i_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_value    (out_ch.inverse_value),
  .out_index    (out_ch.entry_index),
  .out_singular (out_ch.singular),
  .out_clipped  (out_ch.clipped),
  .out_last     (out_ch.last_result)
);
